>>> hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked every clock, off during reset
`define CHK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lbl failed");
// implication checked every clock, off during reset
`define CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbl failed");
`endif

>>> hw/rtl/w2d_pkg.sv
// package for the widening converter: codes, types and a highest-set-bit function
// no dependencies
package w2d_pkg;
  typedef enum logic [2:0] {
    CLS_ZERO = 3'd0,
    CLS_SUB  = 3'd1,
    CLS_NORM = 3'd2,
    CLS_INF  = 3'd3,
    CLS_NAN  = 3'd4
  } value_class_t;

  typedef enum logic [1:0] {
    SZ_HALF   = 2'd0,
    SZ_SINGLE = 2'd1,
    SZ_DOUBLE = 2'd2
  } fmt_size_t;

  localparam logic [63:0] D_QNAN = 64'h7FF8000000000000;
  localparam logic [10:0] D_EMAX = 11'h7FF;

  // fields pulled out of the raw word
  typedef struct packed {
    fmt_size_t   size;
    logic        sgn;
    logic [10:0] expo;
    logic [51:0] frac;
  } fields_t;

  // index of the highest set bit of a 23 bit fraction
  function automatic logic [4:0] top_bit(input logic [22:0] f);
    logic [4:0] p;
    p = 5'd0;
    for (int k = 0; k < 23; k++) begin
      if (f[k]) p = 5'(k);
    end
    return p;
  endfunction
endpackage

>>> hw/rtl/ieee754_widen_to_double.sv
// top level of the half/single/double to binary64 converter
// depends on w2d_pkg, w2d_unpack, w2d_widen, assert_macros.svh
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | func, raw_bytes
//  out     | out_valid | out_stall | value_bits, value_class
//
// one request per cycle sustained while out_stall is low; a result passes the input register, then the result register
// the input register feeds byte ordering, field split and assembly in one pass
// a second (result) register holds the result until the consumer takes it
// in_stall rises only when both registers are full and the output is stalled
// rst clears both valid flags; payload registers are not reset
`include "assert_macros.svh"
module ieee754_widen_to_double (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [63:0] raw_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value_bits,
  output logic [2:0]  value_class
);
  import w2d_pkg::*;

  // input register
  logic        s1_valid;
  logic [2:0]  s1_func;
  logic [63:0] s1_raw;

  fields_t      fields;
  logic [63:0]  conv_bits;
  value_class_t conv_class;

  logic s1_move;
  logic out_load;

  w2d_unpack u_unpack (.func(s1_func), .raw_bytes(s1_raw), .fields(fields));
  w2d_widen  u_widen  (.fields(fields), .value_bits(conv_bits), .value_class(conv_class));

  // result register frees when empty or taken
  assign out_load = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_load;
  // input register frees when empty or moving on
  assign in_stall = s1_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_func <= func;
      s1_raw  <= raw_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      value_bits  <= conv_bits;
      value_class <= conv_class;
    end
  end

  `CHK_IMP(a_stall_needs_full, in_stall, s1_valid && out_valid && out_stall)
  `CHK_IMP(a_out_holds, out_valid && out_stall, ##1 (out_valid && $stable(value_bits)))
  `CHK_IMP(a_nan_bits, out_valid && value_class == CLS_NAN, value_bits == D_QNAN)
  `CHK_IMP(a_zero_bits, out_valid && value_class == CLS_ZERO, value_bits == 64'd0)
endmodule

>>> hw/rtl/w2d_unpack.sv
// byte ordering and field split of the raw input
// depends on w2d_pkg
module w2d_unpack (
  input  logic [2:0]       func,
  input  logic [63:0]      raw_bytes,
  output w2d_pkg::fields_t fields
);
  import w2d_pkg::*;

  logic [63:0] word;
  logic        big;

  assign big = func[0];

  always_comb begin
    word = '0;
    fields = '0;
    case (func[2:1])
      SZ_HALF: begin
        word[15:0] = big ? {raw_bytes[7:0], raw_bytes[15:8]} : raw_bytes[15:0];
        fields.size = SZ_HALF;
        fields.sgn  = word[15];
        fields.expo = {6'd0, word[14:10]};
        fields.frac = {42'd0, word[9:0]};
      end
      SZ_SINGLE: begin
        word[31:0] = big ? {raw_bytes[7:0], raw_bytes[15:8], raw_bytes[23:16],
                            raw_bytes[31:24]} : raw_bytes[31:0];
        fields.size = SZ_SINGLE;
        fields.sgn  = word[31];
        fields.expo = {3'd0, word[30:23]};
        fields.frac = {29'd0, word[22:0]};
      end
      default: begin
        for (int i = 0; i < 8; i++) begin
          word[8*i +: 8] = big ? raw_bytes[8*(7-i) +: 8] : raw_bytes[8*i +: 8];
        end
        fields.size = SZ_DOUBLE;
        fields.sgn  = word[63];
        fields.expo = word[62:52];
        fields.frac = word[51:0];
      end
    endcase
  end
endmodule

>>> hw/rtl/w2d_widen.sv
// classification and binary64 assembly from split fields
// depends on w2d_pkg
module w2d_widen (
  input  w2d_pkg::fields_t     fields,
  output logic [63:0]          value_bits,
  output w2d_pkg::value_class_t value_class
);
  import w2d_pkg::*;

  logic [10:0] emax;
  logic [10:0] bias_adj;
  logic [4:0]  p;
  logic [22:0] f23;
  logic [51:0] sub_frac;
  logic [10:0] sub_exp;

  assign f23 = fields.frac[22:0];
  assign p   = top_bit(f23);

  always_comb begin
    case (fields.size)
      SZ_HALF:   begin emax = 11'h01F; bias_adj = 11'd1008; end
      SZ_SINGLE: begin emax = 11'h0FF; bias_adj = 11'd896;  end
      default:   begin emax = D_EMAX;  bias_adj = 11'd0;    end
    endcase
    // subnormal: p + 1 + 1023 - bias - fbits
    if (fields.size == SZ_HALF) begin
      sub_exp  = 11'd999 + {6'd0, p};
      sub_frac = {42'd0, f23[9:0] & ~(10'd1 << p[3:0])} << (6'd52 - {1'b0, p});
    end else begin
      sub_exp  = 11'd874 + {6'd0, p};
      sub_frac = {29'd0, f23 & ~(23'd1 << p)} << (6'd52 - {1'b0, p});
    end
  end

  always_comb begin
    if (fields.expo == '0 && fields.frac == '0) begin
      value_bits = '0;
      value_class = CLS_ZERO;
    end else if (fields.expo == emax) begin
      if (fields.frac != '0) begin
        value_bits = D_QNAN;
        value_class = CLS_NAN;
      end else begin
        value_bits = {fields.sgn, D_EMAX, 52'd0};
        value_class = CLS_INF;
      end
    end else if (fields.expo == '0) begin
      value_class = CLS_SUB;
      if (fields.size == SZ_DOUBLE) value_bits = {fields.sgn, 11'd0, fields.frac};
      else value_bits = {fields.sgn, sub_exp, sub_frac};
    end else begin
      value_class = CLS_NORM;
      case (fields.size)
        SZ_HALF:   value_bits = {fields.sgn, fields.expo + bias_adj,
                                 fields.frac[9:0], 42'd0};
        SZ_SINGLE: value_bits = {fields.sgn, fields.expo + bias_adj,
                                 fields.frac[22:0], 29'd0};
        default:   value_bits = {fields.sgn, fields.expo, fields.frac};
      endcase
    end
  end
endmodule
